// File: rtl/md4bc_pkg.sv
// md4 checksum package: state enum, round constants and helper functions
// used by the round unit and the top level; no dependencies
package md4bc_pkg;
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] K2 = 32'h5a827999;
	localparam logic [31:0] K3 = 32'h6ed9eba1;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic CFG_KEY_ENABLE = 1'b0;
	localparam logic CFG_KEY_VALUE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_DATA,
		ST_PAD,
		ST_COMP,
		ST_FOLD
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} comp_ctl_t;

	// message word index used by round step i
	function automatic logic [3:0] word_index(input logic [5:0] i);
		logic [3:0] j;
		j = i[3:0];
		if (i < 6'd16) word_index = j;
		else if (i < 6'd32) word_index = {j[1:0], j[3:2]};
		else word_index = {j[0], j[1], j[2], j[3]};
	endfunction

	function automatic logic [4:0] shift_amt(input logic [5:0] i);
		logic [1:0] k;
		k = i[1:0];
		if (i < 6'd16) begin
			unique case (k)
				2'd0: shift_amt = 5'd3;
				2'd1: shift_amt = 5'd7;
				2'd2: shift_amt = 5'd11;
				default: shift_amt = 5'd19;
			endcase
		end else if (i < 6'd32) begin
			unique case (k)
				2'd0: shift_amt = 5'd3;
				2'd1: shift_amt = 5'd5;
				2'd2: shift_amt = 5'd9;
				default: shift_amt = 5'd13;
			endcase
		end else begin
			unique case (k)
				2'd0: shift_amt = 5'd3;
				2'd1: shift_amt = 5'd9;
				2'd2: shift_amt = 5'd11;
				default: shift_amt = 5'd15;
			endcase
		end
	endfunction
endpackage

// File: rtl/md4_block_checksum.sv
// top level of the md4 checksum: byte sequencer, padding and result register
// depends on md4bc_pkg and md4bc_round
//
// channel  signals                               direction
// in       in_valid in_ready data_byte no_data is_last   to block
// out      out_valid out_ready checksum            from block
// cfg      cfg_valid cfg_ready cfg_index cfg_data  to block
//
// an item is transferred in idle, then its byte is written
// every 64th byte (key, data or pad) stalls input
// while the round unit runs 48 steps on the word ram
// a last item adds the pad bytes plus one or two compressions
// first item of a message also writes the four key bytes if enabled
// input is refused while a checksum waits in the output register
// reset loads the chaining constants and clears the byte count
module md4_block_checksum import md4bc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        no_data,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] checksum,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	state_t state_q, state_d, ret_q, ret_d;
	logic        key_en_q;
	logic [31:0] key_q;
	logic [63:0] bits_q;
	logic        started_q;
	logic [1:0]  kcnt_q;
	logic [7:0]  byte_q;
	logic        none_q, last_q;
	logic [3:0]  lcnt_q;
	logic        we;
	logic [7:0]  wbyte;
	logic        count_up, is_len;
	logic        done;
	logic [31:0] fold;
	comp_ctl_t   ctl;
	logic        reinit;
	logic [5:0]  fill;
	logic [5:0]  ppos_q;

	assign fill = bits_q[8:3];
	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_en_q <= 1'b0;
			key_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEY_ENABLE: key_en_q <= cfg_data[0];
				CFG_KEY_VALUE:  key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte written this cycle and where the sequencer goes next
	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		we = 1'b0;
		wbyte = byte_q;
		count_up = 1'b0;
		is_len = 1'b0;
		ctl = '0;
		reinit = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				if (!started_q && key_en_q) state_d = ST_KEY;
				else state_d = ST_DATA;
			end
			ST_KEY: begin
				we = 1'b1; count_up = 1'b1;
				wbyte = key_q[8*kcnt_q +: 8];
				ret_d = (kcnt_q == 2'd3) ? ST_DATA : ST_KEY;
				if (fill == 6'd63) begin
					state_d = ST_COMP; ctl.start = 1'b1;
				end else state_d = ret_d;
			end
			ST_DATA: begin
				we = !none_q; count_up = !none_q;
				ret_d = last_q ? ST_PAD : ST_IDLE;
				if (!none_q && fill == 6'd63) begin
					state_d = ST_COMP; ctl.start = 1'b1;
				end else state_d = ret_d;
			end
			ST_PAD: begin
				// lcnt 0: marker, 1: zeros to 56, 2..9: length bytes
				we = 1'b1;
				is_len = lcnt_q >= 4'd2;
				if (lcnt_q == 4'd0) wbyte = PAD_MARK;
				else if (is_len) wbyte = bits_q[8*(lcnt_q-4'd2) +: 8];
				else wbyte = 8'h00;
				ret_d = (lcnt_q == 4'd9) ? ST_FOLD : ST_PAD;
				if (ppos_q == 6'd63) begin
					state_d = ST_COMP; ctl.start = 1'b1;
				end else state_d = ret_d;
			end
			ST_COMP: if (done) state_d = ret_q;
			ST_FOLD: begin
				if (!out_valid) begin
					reinit = 1'b1; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pad writes use a separate position counter so the length stays frozen
	logic [5:0] waddr;
	assign waddr = (state_q == ST_PAD) ? ppos_q : fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ret_q <= ST_IDLE;
			bits_q <= '0; started_q <= 1'b0; kcnt_q <= '0; lcnt_q <= '0;
			out_valid <= 1'b0; ppos_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == ST_IDLE && in_valid && in_ready) begin
				started_q <= 1'b1; kcnt_q <= '0;
			end
			if (state_q == ST_KEY) kcnt_q <= kcnt_q + 2'd1;
			if (count_up) bits_q <= bits_q + 64'd8;
			if (state_q == ST_DATA) begin
				lcnt_q <= '0; ppos_q <= fill + {5'd0, !none_q};
			end
			if (state_q == ST_PAD) begin
				ppos_q <= ppos_q + 6'd1;
				// marker on byte 55 leaves no room for zeros
				if (lcnt_q == 4'd0 && ppos_q == 6'd55) lcnt_q <= 4'd2;
				else if (lcnt_q == 4'd0 || is_len || ppos_q == 6'd55)
					lcnt_q <= lcnt_q + 4'd1;
			end
			if (state_q == ST_FOLD && !out_valid) begin
				out_valid <= 1'b1; checksum <= fold;
				bits_q <= '0; started_q <= 1'b0;
			end
		end
	end

	// pad compression boundary uses ppos instead of fill
	logic pad_wrap;
	assign pad_wrap = (state_q == ST_PAD) && (ppos_q == 6'd63);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			byte_q <= data_byte; none_q <= no_data; last_q <= is_last;
		end
	end

	comp_ctl_t ctl_r;
	always_comb begin
		ctl_r = ctl;
		if (state_q == ST_PAD) ctl_r.start = pad_wrap;
		ctl_r.done = 1'b0;
	end

	md4bc_round u_round (
		.clk(clk), .arst_n(arst_n), .byte_we(we), .byte_addr(waddr), .byte_data(wbyte),
		.reinit(reinit), .ctl_in(ctl_r), .done(done), .fold(fold)
	);
endmodule

// File: rtl/md4bc_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module md4bc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/md4bc_round.sv
// md4 compression: one round step per cycle through one shared adder/rotator
// depends on md4bc_pkg and md4bc_ram (word store of the block)
module md4bc_round import md4bc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_we,
	input  logic [5:0]  byte_addr,
	input  logic [7:0]  byte_data,
	input  logic        reinit,
	input  comp_ctl_t   ctl_in,
	output logic        done,
	output logic [31:0] fold
);
	logic [31:0] wbuf_q;
	logic        wwe;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	logic [31:0] h_q [4];
	logic [31:0] v_q [4];
	logic [5:0]  step_q;
	logic        run_q, fin_q;
	logic [31:0] b, c, d, f, sum;
	logic [1:0]  t;
	logic [5:0]  cur;
	logic [4:0]  s;

	// assemble little-endian words from bytes
	always_ff @(posedge clk) begin
		if (byte_we) wbuf_q <= {byte_data, wbuf_q[31:8]};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wwe <= 1'b0;
		else wwe <= byte_we && (byte_addr[1:0] == 2'd3);
	end
	logic [3:0] widx_q;
	always_ff @(posedge clk) if (byte_we) widx_q <= byte_addr[5:2];

	// read address is that of the following step, as the ram read is registered
	assign raddr = word_index(ctl_in.start ? 6'd0 : step_q + 6'd1);
	md4bc_ram #(.WIDTH(32), .DEPTH(16)) u_words (
		.clk(clk), .we(wwe), .waddr(widx_q), .wdata(wbuf_q),
		.raddr(raddr), .rdata(rdata)
	);

	assign cur = step_q;
	assign t = 2'd0 - cur[1:0];
	assign b = v_q[t + 2'd1];
	assign c = v_q[t + 2'd2];
	assign d = v_q[t + 2'd3];
	assign s = shift_amt(cur);
	always_comb begin
		if (cur < 6'd16) f = (b & c) | (~b & d);
		else if (cur < 6'd32) f = ((b & c) | (b & d) | (c & d)) + K2;
		else f = (b ^ c ^ d) + K3;
	end
	assign sum = v_q[t] + f + rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3;
			run_q <= 1'b0; fin_q <= 1'b0; step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (reinit) begin
				h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3;
			end
			if (ctl_in.start) begin
				run_q <= 1'b1;
				step_q <= '0;
				for (int k = 0; k < 4; k++) v_q[k] <= h_q[k];
			end else if (run_q) begin
				v_q[t] <= (sum << s) | (sum >> (6'd32 - {1'b0, s}));
				if (step_q == 6'd47) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
				step_q <= step_q + 6'd1;
			end else if (fin_q) begin
				for (int k = 0; k < 4; k++) h_q[k] <= h_q[k] + v_q[k];
			end
		end
	end
	// fin_q pulses while the feed-forward add is taken, so done follows it
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= fin_q;
	end
	assign done = done_q;
	assign fold = h_q[0] ^ h_q[1] ^ h_q[2] ^ h_q[3];
endmodule

// File: rtl/md4bc_checker.sv
// port-level checks for the md4 checksum top level
// depends on md4_block_checksum through the bind below
module md4bc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] checksum
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(checksum)) else $error("out held");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_in_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");
endmodule

bind md4_block_checksum md4bc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .checksum(checksum)
);

// File: tb/sv/tb_md4_block_checksum.sv
// testbench for md4_block_checksum: drives byte messages through the input channel,
// predicts the folded md4 checksum per message and compares the output transfers
// depends on md4bc_pkg and the rtl of md4_block_checksum
`timescale 1ns / 1ps

module tb_md4_block_checksum;
	import md4bc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        no_data;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] checksum;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	md4_block_checksum i_dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// predictor state: chaining words, block bytes, bit count, message flag, config copy
	logic [31:0] chain_q [4];
	logic [7:0]  blk_q [64];
	logic [63:0] bits_q;
	logic        started_q;
	logic        key_en_q;
	logic [31:0] key_val_q;

	logic [31:0] sums_pending [$];
	int          errors;
	int          cycles;
	int          seen_sums;
	int          out_wait;

	function automatic logic [31:0] rol32(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// one md4 compression of blk_q into chain_q
	task automatic md4_compress();
		logic [31:0] w [16];
		logic [31:0] v [4];
		logic [31:0] b, c, d, f, x;
		int t, j, s, idx;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_q[4*i+3], blk_q[4*i+2], blk_q[4*i+1], blk_q[4*i]};
		for (int i = 0; i < 4; i++) v[i] = chain_q[i];
		for (int i = 0; i < 48; i++) begin
			t = (4 - (i % 4)) % 4;
			b = v[(t+1)%4];
			c = v[(t+2)%4];
			d = v[(t+3)%4];
			j = i % 16;
			if (i < 16) begin
				f = (b & c) | (~b & d);
				x = w[j];
				s = (j%4 == 0) ? 3 : (j%4 == 1) ? 7 : (j%4 == 2) ? 11 : 19;
			end else if (i < 32) begin
				f = ((b & c) | (b & d) | (c & d)) + K2;
				x = w[((j%4) << 2) | (j >> 2)];
				s = (j%4 == 0) ? 3 : (j%4 == 1) ? 5 : (j%4 == 2) ? 9 : 13;
			end else begin
				f = (b ^ c ^ d) + K3;
				// bit reversed word order in the third round
				idx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
				x = w[idx];
				s = (j%4 == 0) ? 3 : (j%4 == 1) ? 9 : (j%4 == 2) ? 11 : 15;
			end
			v[t] = rol32(v[t] + f + x, s);
		end
		for (int i = 0; i < 4; i++) chain_q[i] += v[i];
	endtask

	task automatic put_byte(logic [7:0] bv);
		int pos;
		pos = bits_q[8:3];
		blk_q[pos] = bv;
		if (pos == 63) md4_compress();
	endtask

	task automatic absorb_byte(logic [7:0] bv);
		put_byte(bv);
		bits_q += 64'd8;
	endtask

	task automatic chain_init();
		chain_q[0] = IV0; chain_q[1] = IV1; chain_q[2] = IV2; chain_q[3] = IV3;
		bits_q = '0;
		started_q = 1'b0;
	endtask

	// padding and length, then fold the digest; the length is captured before the pad bytes
	task automatic finish_message(output logic [31:0] sum);
		logic [63:0] len;
		len = bits_q;
		put_byte(PAD_MARK);
		bits_q += 64'd8;
		while (bits_q[8:3] != 6'd56) begin
			put_byte(8'h00);
			bits_q += 64'd8;
		end
		for (int i = 0; i < 8; i++) begin
			put_byte(len[8*i +: 8]);
			bits_q += 64'd8;
		end
		sum = chain_q[0] ^ chain_q[1] ^ chain_q[2] ^ chain_q[3];
		chain_init();
	endtask

	task automatic predict_item(logic [7:0] bv, logic nd, logic lst);
		logic [31:0] sum;
		if (!started_q) begin
			started_q = 1'b1;
			if (key_en_q) for (int i = 0; i < 4; i++) absorb_byte(key_val_q[8*i +: 8]);
		end
		if (!nd) absorb_byte(bv);
		if (lst) begin
			finish_message(sum);
			sums_pending.push_back(sum);
		end
	endtask

	// one item transfer with a random lead gap; returns at the falling edge after
	// acceptance with valid still high, a later gap or drain lowers it
	task automatic send_item(logic [7:0] bv, logic nd, logic lst);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte <= bv;
		no_data <= nd;
		is_last <= lst;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(bv, nd, lst);
		@(negedge clk);
	endtask

	// config transfer, only issued with nothing outstanding
	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_KEY_ENABLE) key_en_q = val[0];
		else key_val_q = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sums_pending.size() != 0) @(negedge clk);
		// messages end with a checksum, so the block is idle once all have arrived
		repeat (4) @(negedge clk);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0), i == len - 1);
	endtask

	// output side: ready is raised after a random wait per transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_ready && !out_valid) begin
				out_ready <= 1'b0;
				out_wait = $urandom_range(0, 5);
			end else if (out_valid && !out_ready) begin
				if (out_wait == 0) out_ready <= 1'b1;
				else out_wait--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_sums++;
			if (sums_pending.size() == 0) begin
				$display("%0t: checksum with nothing expected, actual %h", $time, checksum);
				errors++;
			end else begin
				if (checksum !== sums_pending[0]) begin
					$display("%0t: checksum mismatch, expected %h actual %h",
						$time, sums_pending[0], checksum);
					errors++;
				end
				void'(sums_pending.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb_md4_block_checksum: done, errors");
			$finish;
		end
	end

	// directed table: data byte, no byte flag, last flag
	typedef struct {
		logic [7:0] bv;
		logic       nd;
		logic       lst;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{8'h00, 1'b1, 1'b1},   // empty message
		'{8'h61, 1'b0, 1'b1},   // single byte
		'{8'h00, 1'b0, 1'b0},   // extreme bytes with a byte-less item mid message
		'{8'hff, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0},
		'{8'h55, 1'b0, 1'b0},
		'{8'haa, 1'b0, 1'b1},
		'{8'h00, 1'b1, 1'b0},   // byte-less start then byte-less end
		'{8'hff, 1'b1, 1'b1},
		'{8'hff, 1'b0, 1'b1}
	};

	initial begin
		int len;
		errors = 0;
		cycles = 0;
		seen_sums = 0;
		out_wait = $urandom_range(0, 5);
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		no_data = 1'b0;
		is_last = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KEY_ENABLE;
		cfg_data = '0;
		key_en_q = 1'b0;
		key_val_q = '0;
		chain_init();
		for (int i = 0; i < 64; i++) blk_q[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_item(dir_rows[i].bv, dir_rows[i].nd, dir_rows[i].lst);
		drain();

		// lengths around the 55/56/64 padding boundaries, key off then extreme keys
		for (int k = 0; k < 3; k++) begin
			if (k == 1) begin
				write_reg(CFG_KEY_ENABLE, 32'd1);
				write_reg(CFG_KEY_VALUE, 32'hffffffff);
			end else if (k == 2) begin
				write_reg(CFG_KEY_VALUE, 32'h00000000);
			end
			send_message(55);
			send_message(56);
			send_message(64);
			send_item(8'h00, 1'b1, 1'b1);
			drain();
		end

		// random part: phases with varied keys, short messages mostly, a few long ones
		len = 0;
		while (len < 1200) begin
			int mlen;
			write_reg(CFG_KEY_ENABLE, $urandom_range(0, 1));
			write_reg(CFG_KEY_VALUE, $urandom());
			for (int m = 0; m < 8; m++) begin
				mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
				send_message(mlen);
				len += mlen;
			end
			drain();
		end

		drain();
		repeat (300) @(negedge clk);
		if (errors == 0 && sums_pending.size() == 0) begin
			$display("tb_md4_block_checksum: done, clean");
		end else begin
			$display("tb_md4_block_checksum: done, errors");
		end
		$finish;
	end
endmodule
